### sv/scpa_pkg.sv
`default_nettype none
package scpa_pkg;

  localparam int unsigned Slots = 16;
  localparam int unsigned NumClasses = 9;
  localparam int unsigned PageBytes = 4096;

  typedef enum logic [1:0] {
    ACT_ALLOC = 2'd0,
    ACT_FREE  = 2'd1,
    ACT_SIZE  = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_SIZE  = 2'd1,
    ST_NO_PAGES  = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_SCAN, S_DECIDE, S_CLEAR, S_RD, S_CHK, S_FRD, S_FCHK, S_DONE
  } state_e;

  typedef struct packed {
    logic        we;
    logic [7:0]  waddr;
    logic [15:0] wdata;
    logic        re;
    logic [7:0]  raddr;
  } bm_ctrl_t;

  function automatic logic [12:0] class_bytes(input logic [3:0] code);
    logic [12:0] r;
    r = 13'd0;
    if (code != 4'd0) r = 13'(PageBytes >> (code - 4'd1));
    return r;
  endfunction

  function automatic logic [3:0] req_code(input logic [12:0] req);
    logic [3:0] r;
    logic       hit;
    r = 4'd1;
    hit = 1'b0;
    for (int c = NumClasses; c >= 1; c--) begin
      if (!hit && (class_bytes(4'(c)) >= req)) begin
        r = 4'(c);
        hit = 1'b1;
      end
    end
    return r;
  endfunction

  // grains of one bitmap word that sit on class boundaries
  function automatic logic [15:0] cand_mask(input logic [3:0] code, input logic [3:0] w);
    logic [15:0] m;
    logic [3:0]  smask;
    logic [3:0]  wmask;
    m = 16'd0;
    if (code >= 4'd6) begin
      smask = 4'((5'd1 << (4'd9 - code)) - 5'd1);
      for (int i = 0; i < 16; i++) m[i] = ((4'(i) & smask) == 4'd0);
    end else begin
      wmask = 4'((5'd1 << (4'd5 - code)) - 5'd1);
      m[0] = ((w & wmask) == 4'd0);
    end
    return m;
  endfunction

endpackage
`default_nettype wire

### sv/size_class_page_allocator_top.sv
// size queries, rejects and misses go from dispatch straight to the result beat; free adds a read and a write-back
// allocate: a slot scan of one slot a cycle, then a clear of all 16 words of a newly
// claimed slot or up to 16 bitmap words, each read then checked, through a one-read one-write memory
// one item at a time; input ready again in the cycle the result beat is registered
// reset: async active low, all slots empty, max_pages 16, no clearing pass
`default_nettype none
module size_class_page_allocator_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // req_size[12:0], obj_address[28:13]
  input  wire logic [1:0]  s_axis_tuser,   // action[1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // out_address[15:0], class_bytes[28:16]
  output logic [1:0]       m_axis_tuser,   // status[1:0]
  input  wire logic        cfg_we_i,
  input  wire logic [4:0]  cfg_wdata_i
);

  scpa_pkg::state_e state_q, state_d;
  scpa_pkg::bm_ctrl_t bm;

  logic [3:0]  slot_class_q [16];
  logic [8:0]  slot_count_q [16];
  logic [4:0]  created_q, pages_q, max_pages_q, scan_q;
  logic [1:0]  act_q;
  logic [12:0] req_q;
  logic [15:0] addr_q;
  logic [3:0]  code_q, slot_q, w_q, mslot_q, eslot_q, t;
  logic        mfound_q, efound_q;
  logic [1:0]  rs_status_q;
  logic [15:0] rs_addr_q;
  logic [12:0] rs_cls_q;
  logic        out_valid_q;
  logic [1:0]  out_status_q;
  logic [15:0] out_addr_q;
  logic [12:0] out_cls_q;
  logic [15:0] rdata;
  logic        hit;
  logic [3:0]  hbit;
  logic [3:0]  fslot;
  logic        fmiss;
  logic        bad_size;
  logic [8:0]  cnt_dec;

  assign t        = scan_q[3:0] - 4'd1;
  assign fslot    = addr_q[15:12];
  assign fmiss    = ({1'b0, fslot} >= created_q) || (slot_class_q[fslot] == 4'd0);
  assign bad_size = (req_q == 13'd0) || (req_q > 13'(scpa_pkg::PageBytes));
  assign cnt_dec  = slot_count_q[slot_q] - 9'd1;

  scpa_bitmap u_bitmap (
    .clk_i  (clk_i),
    .ctrl_i (bm),
    .code_i (code_q),
    .rdata_o(rdata),
    .hit_o  (hit),
    .bit_o  (hbit)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      scpa_pkg::S_IDLE: if (s_axis_tvalid) state_d = scpa_pkg::S_DISPATCH;
      scpa_pkg::S_DISPATCH: begin
        unique case (scpa_pkg::action_e'(act_q))
          scpa_pkg::ACT_ALLOC: state_d = bad_size ? scpa_pkg::S_DONE : scpa_pkg::S_SCAN;
          scpa_pkg::ACT_FREE:  state_d = fmiss ? scpa_pkg::S_DONE : scpa_pkg::S_FRD;
          scpa_pkg::ACT_SIZE:  state_d = scpa_pkg::S_DONE;
          scpa_pkg::ACT_NONE:  state_d = scpa_pkg::S_DONE;
          default:             state_d = scpa_pkg::S_DONE;
        endcase
      end
      scpa_pkg::S_SCAN: if (scan_q == 5'd0) state_d = scpa_pkg::S_DECIDE;
      scpa_pkg::S_DECIDE: begin
        priority if (mfound_q) state_d = scpa_pkg::S_RD;
        else if (pages_q < max_pages_q && (efound_q || created_q < 5'(scpa_pkg::Slots)))
          state_d = scpa_pkg::S_CLEAR;
        else state_d = scpa_pkg::S_DONE;
      end
      scpa_pkg::S_CLEAR: if (w_q == 4'd15) state_d = scpa_pkg::S_DONE;
      scpa_pkg::S_RD:    state_d = scpa_pkg::S_CHK;
      scpa_pkg::S_CHK:   state_d = (hit || w_q == 4'd15) ? scpa_pkg::S_DONE : scpa_pkg::S_RD;
      scpa_pkg::S_FRD:   state_d = scpa_pkg::S_FCHK;
      scpa_pkg::S_FCHK:  state_d = scpa_pkg::S_DONE;
      scpa_pkg::S_DONE:  if (!out_valid_q || m_axis_tready) state_d = scpa_pkg::S_IDLE;
      default:           state_d = scpa_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    bm = '0;
    unique case (state_q)
      scpa_pkg::S_CLEAR: begin
        bm.we    = 1'b1;
        bm.waddr = {slot_q, w_q};
        bm.wdata = (w_q == 4'd0) ? 16'd1 : 16'd0;
      end
      scpa_pkg::S_RD: begin
        bm.re    = 1'b1;
        bm.raddr = {slot_q, w_q};
      end
      scpa_pkg::S_CHK: begin
        bm.we    = hit;
        bm.waddr = {slot_q, w_q};
        bm.wdata = rdata | (16'd1 << hbit);
      end
      scpa_pkg::S_FRD: begin
        bm.re    = 1'b1;
        bm.raddr = {slot_q, addr_q[11:8]};
      end
      scpa_pkg::S_FCHK: begin
        bm.we    = 1'b1;
        bm.waddr = {slot_q, addr_q[11:8]};
        bm.wdata = rdata & ~(16'd1 << addr_q[7:4]);
      end
      default: bm = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= scpa_pkg::S_IDLE;
      created_q   <= 5'd0;
      pages_q     <= 5'd0;
      max_pages_q <= 5'd16;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 16; i++) begin
        slot_class_q[i] <= 4'd0;
        slot_count_q[i] <= 9'd0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) max_pages_q <= cfg_wdata_i;
      if (state_q == scpa_pkg::S_DONE && (!out_valid_q || m_axis_tready)) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
      unique case (state_q)
        scpa_pkg::S_IDLE: begin
          if (s_axis_tvalid) begin
            act_q  <= s_axis_tuser;
            req_q  <= s_axis_tdata[12:0];
            addr_q <= s_axis_tdata[28:13];
          end
        end
        scpa_pkg::S_DISPATCH: begin
          rs_addr_q   <= 16'd0;
          rs_cls_q    <= (scpa_pkg::action_e'(act_q) == scpa_pkg::ACT_SIZE && !fmiss) ?
                         scpa_pkg::class_bytes(slot_class_q[fslot]) : 13'd0;
          code_q      <= scpa_pkg::req_code(req_q);
          scan_q      <= created_q;
          mfound_q    <= 1'b0;
          efound_q    <= 1'b0;
          slot_q      <= fslot;
          w_q         <= 4'd0;
          unique case (scpa_pkg::action_e'(act_q))
            scpa_pkg::ACT_ALLOC:
              rs_status_q <= bad_size ? scpa_pkg::ST_BAD_SIZE : scpa_pkg::ST_OK;
            scpa_pkg::ACT_FREE:
              rs_status_q <= fmiss ? scpa_pkg::ST_NOT_FOUND : scpa_pkg::ST_OK;
            scpa_pkg::ACT_SIZE:
              rs_status_q <= fmiss ? scpa_pkg::ST_NOT_FOUND : scpa_pkg::ST_OK;
            scpa_pkg::ACT_NONE: rs_status_q <= scpa_pkg::ST_OK;
            default:            rs_status_q <= scpa_pkg::ST_OK;
          endcase
        end
        scpa_pkg::S_SCAN: begin
          if (scan_q != 5'd0) begin
            scan_q <= scan_q - 5'd1;
            if (!mfound_q && slot_class_q[t] == code_q &&
                {1'b0, slot_count_q[t]} < (10'd1 << (code_q - 4'd1))) begin
              mfound_q <= 1'b1;
              mslot_q  <= t;
            end
            if (!efound_q && slot_class_q[t] == 4'd0) begin
              efound_q <= 1'b1;
              eslot_q  <= t;
            end
          end
        end
        scpa_pkg::S_DECIDE: begin
          priority if (mfound_q) begin
            slot_q <= mslot_q;
          end else if (pages_q < max_pages_q && efound_q) begin
            slot_q               <= eslot_q;
            slot_class_q[eslot_q] <= code_q;
            slot_count_q[eslot_q] <= 9'd1;
            pages_q              <= pages_q + 5'd1;
          end else if (pages_q < max_pages_q && created_q < 5'(scpa_pkg::Slots)) begin
            slot_q                      <= created_q[3:0];
            slot_class_q[created_q[3:0]] <= code_q;
            slot_count_q[created_q[3:0]] <= 9'd1;
            pages_q                     <= pages_q + 5'd1;
            created_q                   <= created_q + 5'd1;
          end else begin
            rs_status_q <= scpa_pkg::ST_NO_PAGES;
          end
        end
        scpa_pkg::S_CLEAR: begin
          w_q       <= w_q + 4'd1;
          rs_addr_q <= {slot_q, 12'd0};
          rs_cls_q  <= scpa_pkg::class_bytes(code_q);
        end
        scpa_pkg::S_RD: ;
        scpa_pkg::S_CHK: begin
          if (hit) begin
            slot_count_q[slot_q] <= slot_count_q[slot_q] + 9'd1;
            rs_addr_q            <= {slot_q, w_q, hbit, 4'd0};
            rs_cls_q             <= scpa_pkg::class_bytes(code_q);
          end else if (w_q == 4'd15) begin
            rs_status_q <= scpa_pkg::ST_NO_PAGES;
          end else begin
            w_q <= w_q + 4'd1;
          end
        end
        scpa_pkg::S_FRD: ;
        scpa_pkg::S_FCHK: begin
          slot_count_q[slot_q] <= cnt_dec;
          if (cnt_dec == 9'd0) begin
            slot_class_q[slot_q] <= 4'd0;
            if (pages_q != 5'd0) pages_q <= pages_q - 5'd1;
          end
        end
        scpa_pkg::S_DONE: begin
          if (!out_valid_q || m_axis_tready) begin
            out_status_q <= rs_status_q;
            out_addr_q   <= rs_addr_q;
            out_cls_q    <= rs_cls_q;
          end
        end
        default: ;
      endcase
    end
  end

  assign s_axis_tready = (state_q == scpa_pkg::S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'd0, out_cls_q, out_addr_q};
  assign m_axis_tuser  = out_status_q;

  a_pages_le_created: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pages_q <= created_q) else $error("more pages held than slots created");
  a_created_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    created_q <= 5'(scpa_pkg::Slots)) else $error("slot count overflow");
  a_clear_claimed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == scpa_pkg::S_CLEAR |-> slot_class_q[slot_q] == code_q)
    else $error("clearing a slot that was not claimed");
  a_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == scpa_pkg::S_DONE && (!out_valid_q || m_axis_tready) |=> out_valid_q)
    else $error("result beat lost");

endmodule
`default_nettype wire

### sv/scpa_bitmap.sv
`default_nettype none
module scpa_bitmap (
  input  wire logic               clk_i,
  input  wire scpa_pkg::bm_ctrl_t ctrl_i,
  input  wire logic [3:0]         code_i,
  output logic [15:0]             rdata_o,
  output logic                    hit_o,
  output logic [3:0]              bit_o
);

  logic [15:0] mem [256];
  logic [15:0] rdata_q;
  logic [3:0]  rword_q;
  logic [15:0] free_bits;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.we) mem[ctrl_i.waddr] <= ctrl_i.wdata;
    if (ctrl_i.re) begin
      rdata_q <= mem[ctrl_i.raddr];
      rword_q <= ctrl_i.raddr[3:0];
    end
  end

  assign free_bits = ~rdata_q & scpa_pkg::cand_mask(code_i, rword_q);

  always_comb begin
    bit_o = 4'd0;
    for (int i = 15; i >= 0; i--) begin
      if (free_bits[i]) bit_o = 4'(i);
    end
  end

  assign hit_o   = |free_bits;
  assign rdata_o = rdata_q;

endmodule
`default_nettype wire
